// File: design/rk4_pkg.sv
// ----------------------------------------------------------------------------
// RK4 integrator package
// Shared widths, reset values, state and opcode types, and the micro-program
// that the sequencer steps through for one Runge-Kutta step.
// ----------------------------------------------------------------------------
package rk4_pkg;

  localparam int unsigned XW            = 32;  // Q16.16 data width
  localparam int unsigned HW            = 31;  // step size register width
  localparam int unsigned CNT_W         = 6;   // step count width
  localparam int unsigned MAX_STEPS_DEF = 63;
  localparam int unsigned NUM_UOPS      = 30;
  localparam int unsigned PC_W          = $clog2(NUM_UOPS);

  localparam logic [HW-1:0] STEP_RESET = 31'd6554;  // about 0.1
  // ceil(2^34 / 6): exact floor(m / 6) for any 32-bit m after a shift by 34
  localparam logic [31:0]   RECIP6     = 32'hAAAA_AAAB;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EMIT,
    ST_ISSUE,
    ST_WB
  } state_e;

  typedef enum logic [3:0] {
    OP_ADD,   // sat(a + b)
    OP_MUL,   // sat(round(a * b / 2^16))
    OP_NEG3,  // sat(-3 * a)
    OP_HALF,  // a >>> 1
    OP_ACCI,  // acc = a
    OP_ACC2,  // acc += 2 * a
    OP_ACCF,  // sat(acc + a)
    OP_ABS3,  // |a| + 3, remembers the sign
    OP_DIV6   // floor(a / 6) of unsigned a, negated by the remembered sign
  } alu_op_e;

  typedef enum logic [3:0] {
    RS_NONE,
    RS_X,
    RS_Y,
    RS_H,
    RS_HH,
    RS_XM,
    RS_XE,
    RS_YT,
    RS_K,
    RS_T1,
    RS_T2
  } reg_sel_e;

  typedef struct packed {
    alu_op_e  op;
    reg_sel_e src_a;
    reg_sel_e src_b;
    reg_sel_e dst;
  } uop_t;

  typedef struct packed {
    alu_op_e            op;
    logic signed [31:0] a;
    logic signed [31:0] b;
  } alu_req_t;

  typedef struct packed {
    logic signed [31:0] result;
    logic               sat;
  } alu_rsp_t;

  // One RK4 step: k1..k4, weighted sum, scale by h, divide by 6, update y.
  function automatic uop_t rk4_uop(input logic [PC_W-1:0] pc);
    uop_t u;
    u = '{OP_HALF, RS_NONE, RS_NONE, RS_NONE};
    unique case (pc)
      5'd0:  u = '{OP_ADD,  RS_X,  RS_HH,   RS_XM};
      5'd1:  u = '{OP_ADD,  RS_X,  RS_H,    RS_XE};
      5'd2:  u = '{OP_NEG3, RS_Y,  RS_NONE, RS_T1};
      5'd3:  u = '{OP_MUL,  RS_X,  RS_X,    RS_T2};
      5'd4:  u = '{OP_ADD,  RS_T1, RS_T2,   RS_K};
      5'd5:  u = '{OP_ACCI, RS_K,  RS_NONE, RS_NONE};
      5'd6:  u = '{OP_MUL,  RS_K,  RS_H,    RS_T1};
      5'd7:  u = '{OP_HALF, RS_T1, RS_NONE, RS_T1};
      5'd8:  u = '{OP_ADD,  RS_Y,  RS_T1,   RS_YT};
      5'd9:  u = '{OP_NEG3, RS_YT, RS_NONE, RS_T1};
      5'd10: u = '{OP_MUL,  RS_XM, RS_XM,   RS_T2};
      5'd11: u = '{OP_ADD,  RS_T1, RS_T2,   RS_K};
      5'd12: u = '{OP_ACC2, RS_K,  RS_NONE, RS_NONE};
      5'd13: u = '{OP_MUL,  RS_K,  RS_H,    RS_T1};
      5'd14: u = '{OP_HALF, RS_T1, RS_NONE, RS_T1};
      5'd15: u = '{OP_ADD,  RS_Y,  RS_T1,   RS_YT};
      5'd16: u = '{OP_NEG3, RS_YT, RS_NONE, RS_T1};
      5'd17: u = '{OP_MUL,  RS_XM, RS_XM,   RS_T2};
      5'd18: u = '{OP_ADD,  RS_T1, RS_T2,   RS_K};
      5'd19: u = '{OP_ACC2, RS_K,  RS_NONE, RS_NONE};
      5'd20: u = '{OP_MUL,  RS_K,  RS_H,    RS_T1};
      5'd21: u = '{OP_ADD,  RS_Y,  RS_T1,   RS_YT};
      5'd22: u = '{OP_NEG3, RS_YT, RS_NONE, RS_T1};
      5'd23: u = '{OP_MUL,  RS_XE, RS_XE,   RS_T2};
      5'd24: u = '{OP_ADD,  RS_T1, RS_T2,   RS_K};
      5'd25: u = '{OP_ACCF, RS_K,  RS_NONE, RS_T1};
      5'd26: u = '{OP_MUL,  RS_T1, RS_H,    RS_T1};
      5'd27: u = '{OP_ABS3, RS_T1, RS_NONE, RS_T1};
      5'd28: u = '{OP_DIV6, RS_T1, RS_NONE, RS_T1};
      5'd29: u = '{OP_ADD,  RS_Y,  RS_T1,   RS_Y};
      default: u = '{OP_HALF, RS_NONE, RS_NONE, RS_NONE};
    endcase
    return u;
  endfunction

endpackage

// File: design/rk4_if.sv
// ----------------------------------------------------------------------------
// RK4 integrator channels
// Valid/ready channels for run requests and for solution points.
// ----------------------------------------------------------------------------
interface rk4_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] start_x;
  logic signed [31:0] start_y;
  logic [5:0]         step_count;

  modport source (output valid, output start_x, output start_y, output step_count,
                  input ready);
  modport sink   (input valid, input start_x, input start_y, input step_count,
                  output ready);
endinterface

interface rk4_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] point_x;
  logic signed [31:0] point_y;
  logic               last_point;
  logic               saturated;

  modport source (output valid, output point_x, output point_y, output last_point,
                  output saturated, input ready);
  modport sink   (input valid, input point_x, input point_y, input last_point,
                  input saturated, output ready);
endinterface

// File: design/rk4_alu.sv
// ----------------------------------------------------------------------------
// RK4 shared arithmetic unit
// Saturating Q16.16 unit: one multiplier or wide adder per issue,
// rounding and saturation in the following cycle.
// ----------------------------------------------------------------------------
module rk4_alu import rk4_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     issue_i,
  input  alu_req_t req_i,
  output alu_rsp_t rsp_o
);

  alu_op_e            op_q;
  logic signed [34:0] a_ext;
  logic signed [34:0] b_ext;
  logic signed [32:0] mul_a;
  logic signed [32:0] mul_b;
  logic signed [65:0] prod_d, prod_q;
  logic signed [34:0] wide_d, wide_q;
  logic signed [34:0] acc_d, acc_q;
  logic               neg_d, neg_q;
  logic [63:0]        rnd;
  logic [47:0]        shr;
  logic [31:0]        quo;

  assign a_ext = {{3{req_i.a[31]}}, req_i.a};
  assign b_ext = {{3{req_i.b[31]}}, req_i.b};
  assign mul_a = (req_i.op == OP_DIV6) ? {1'b0, req_i.a} : {req_i.a[31], req_i.a};
  assign mul_b = (req_i.op == OP_DIV6) ? {1'b0, RECIP6} : {req_i.b[31], req_i.b};
  assign prod_d = mul_a * mul_b;

  // Issue stage: exact wide value, accumulator and sign tracking
  always_comb begin
    wide_d = '0;
    acc_d  = acc_q;
    neg_d  = neg_q;
    unique case (req_i.op) inside
      OP_ADD:  wide_d = a_ext + b_ext;
      OP_NEG3: wide_d = 35'sd0 - (a_ext + (a_ext <<< 1));
      OP_HALF: wide_d = a_ext >>> 1;
      OP_ACCI: acc_d  = a_ext;
      OP_ACC2: acc_d  = acc_q + (a_ext <<< 1);
      OP_ACCF: wide_d = acc_q + a_ext;
      OP_ABS3: begin
        wide_d = req_i.a[31] ? (~a_ext + 35'sd4) : (a_ext + 35'sd3);
        neg_d  = req_i.a[31];
      end
      OP_MUL, OP_DIV6: wide_d = '0;
      default: wide_d = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      op_q  <= OP_HALF;
      acc_q <= '0;
      neg_q <= 1'b0;
    end else if (issue_i) begin
      op_q  <= req_i.op;
      acc_q <= acc_d;
      neg_q <= neg_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (issue_i) begin
      prod_q <= prod_d;
      wide_q <= wide_d;
    end
  end

  // Result stage: round, scale and clamp to the Q16.16 range
  assign rnd = prod_q[63:0] + 64'd32768;
  assign shr = rnd[63:16];
  assign quo = {2'b00, prod_q[63:34]};

  always_comb begin
    rsp_o.result = wide_q[31:0];
    rsp_o.sat    = 1'b0;
    unique case (op_q) inside
      OP_MUL: begin
        if ((&shr[47:31]) || !(|shr[47:31])) begin
          rsp_o.result = shr[31:0];
        end else begin
          rsp_o.sat    = 1'b1;
          rsp_o.result = shr[47] ? 32'h8000_0000 : 32'h7FFF_FFFF;
        end
      end
      OP_ADD, OP_NEG3, OP_ACCF: begin
        if ((&wide_q[34:31]) || !(|wide_q[34:31])) begin
          rsp_o.result = wide_q[31:0];
        end else begin
          rsp_o.sat    = 1'b1;
          rsp_o.result = wide_q[34] ? 32'h8000_0000 : 32'h7FFF_FFFF;
        end
      end
      OP_DIV6: rsp_o.result = neg_q ? (32'd0 - quo) : quo;
      OP_HALF, OP_ABS3: rsp_o.result = wide_q[31:0];
      OP_ACCI, OP_ACC2: rsp_o.result = '0;
      default: rsp_o.result = '0;
    endcase
  end

`ifndef SYNTHESIS
  // A pure shift, magnitude or divide never reports saturation
  a_no_sat_on_exact: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (op_q == OP_HALF || op_q == OP_ABS3 || op_q == OP_DIV6) |-> !rsp_o.sat)
    else $error("saturation reported on an exact operation");
  // The reciprocal product always fits in 64 bits
  a_div6_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (op_q == OP_DIV6) |-> (prod_q[65:64] == 2'b00))
    else $error("reciprocal product out of range");
  // An issued accumulate start loads the operand
  a_acc_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (issue_i && req_i.op == OP_ACCI) |=> (acc_q == $past(a_ext)))
    else $error("accumulator did not load");
`endif

endmodule

// File: design/rk4_ode_integrator.sv
// ----------------------------------------------------------------------------
// RK4 ODE integrator
// Fixed-point fourth-order Runge-Kutta solver for dy/dx = -3y + x^2.
// ----------------------------------------------------------------------------
// One transfer on the input channel starts a run at (start_x, start_y). The
// block first sends that starting point, then one (x, y) point per RK4 step,
// step_count steps in all (clamped to MAX_STEPS), and marks the final point
// with last_point. All values are signed Q16.16; any overflow saturates,
// and saturated reports whether any saturation happened so far in the run.
// The step size h is set through cfg_we_i/cfg_wdata_i (reset 6554, about
// 0.1) and must only change while no run is in flight. Each step is a fixed
// 30-operation micro-program on one shared arithmetic unit, issue plus
// writeback per operation, followed by the point hand-off. The block takes
// a new run only when the previous one has produced its last point; that
// point may still sit in the output register while the next run starts.
// ----------------------------------------------------------------------------
module rk4_ode_integrator import rk4_pkg::*; #(
  parameter int unsigned MAX_STEPS = MAX_STEPS_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cfg_we_i,
  input  logic [HW-1:0] cfg_wdata_i,
  rk4_in_if.sink        in_i,
  rk4_out_if.source     out_o
);

  localparam logic [PC_W-1:0]  LAST_UOP = PC_W'(NUM_UOPS - 1);
  localparam logic [CNT_W-1:0] STEP_CAP = CNT_W'(MAX_STEPS);

  state_e             state_d, state_q;
  logic [HW-1:0]      step_size_q;
  logic [PC_W-1:0]    pc_q;
  logic [CNT_W-1:0]   step_q;
  logic [CNT_W-1:0]   steps_q;
  logic               sat_q;
  logic signed [31:0] x_q, y_q, hh_q, xm_q, xe_q, yt_q, k_q, t1_q, t2_q;
  logic signed [31:0] h_val;

  logic               out_valid_q;
  logic signed [31:0] out_x_q, out_y_q;
  logic               out_last_q, out_sat_q;

  uop_t               uop;
  alu_req_t           alu_req;
  alu_rsp_t           alu_rsp;
  logic               alu_issue;
  logic               in_xfer;
  logic               out_load;
  logic               pt_last;

  assign h_val   = {1'b0, step_size_q};
  assign uop     = rk4_uop(pc_q);
  assign pt_last = (step_q == steps_q);

  // Configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_size_q <= STEP_RESET;
    end else if (cfg_we_i) begin
      step_size_q <= cfg_wdata_i;
    end
  end

  // Operand selection for the shared unit
  always_comb begin
    alu_req.op = uop.op;
    case (uop.src_a)
      RS_X:    alu_req.a = x_q;
      RS_Y:    alu_req.a = y_q;
      RS_H:    alu_req.a = h_val;
      RS_HH:   alu_req.a = hh_q;
      RS_XM:   alu_req.a = xm_q;
      RS_XE:   alu_req.a = xe_q;
      RS_YT:   alu_req.a = yt_q;
      RS_K:    alu_req.a = k_q;
      RS_T1:   alu_req.a = t1_q;
      RS_T2:   alu_req.a = t2_q;
      default: alu_req.a = '0;
    endcase
    case (uop.src_b)
      RS_X:    alu_req.b = x_q;
      RS_Y:    alu_req.b = y_q;
      RS_H:    alu_req.b = h_val;
      RS_HH:   alu_req.b = hh_q;
      RS_XM:   alu_req.b = xm_q;
      RS_XE:   alu_req.b = xe_q;
      RS_YT:   alu_req.b = yt_q;
      RS_K:    alu_req.b = k_q;
      RS_T1:   alu_req.b = t1_q;
      RS_T2:   alu_req.b = t2_q;
      default: alu_req.b = '0;
    endcase
  end

  rk4_alu u_alu (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .issue_i (alu_issue),
    .req_i   (alu_req),
    .rsp_o   (alu_rsp)
  );

  // Sequencer: next state and handshake outputs
  always_comb begin
    state_d   = state_q;
    in_i.ready = 1'b0;
    alu_issue = 1'b0;
    out_load  = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_i.ready = 1'b1;
        if (in_i.valid) begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        // Load the output register once it is free or being drained
        if (!out_valid_q || out_o.ready) begin
          out_load = 1'b1;
          state_d  = pt_last ? ST_IDLE : ST_ISSUE;
        end
      end
      ST_ISSUE: begin
        alu_issue = 1'b1;
        state_d   = ST_WB;
      end
      ST_WB: begin
        state_d = (pc_q == LAST_UOP) ? ST_EMIT : ST_ISSUE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign in_xfer = in_i.valid && in_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      pc_q    <= '0;
      step_q  <= '0;
      steps_q <= '0;
      sat_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      if (in_xfer) begin
        pc_q    <= '0;
        step_q  <= '0;
        steps_q <= (in_i.step_count > STEP_CAP) ? STEP_CAP : in_i.step_count;
        sat_q   <= 1'b0;
      end else if (state_q == ST_WB) begin
        sat_q <= sat_q | alu_rsp.sat;
        if (pc_q == LAST_UOP) begin
          pc_q   <= '0;
          step_q <= step_q + CNT_W'(1);
        end else begin
          pc_q <= pc_q + PC_W'(1);
        end
      end
    end
  end

  // Working registers: load on a new run, write back after each operation
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      x_q  <= in_i.start_x;
      y_q  <= in_i.start_y;
      hh_q <= {2'b00, step_size_q[HW-1:1]};
    end else if (state_q == ST_WB) begin
      case (uop.dst)
        RS_Y:    y_q  <= alu_rsp.result;
        RS_XM:   xm_q <= alu_rsp.result;
        RS_XE:   xe_q <= alu_rsp.result;
        RS_YT:   yt_q <= alu_rsp.result;
        RS_K:    k_q  <= alu_rsp.result;
        RS_T1:   t1_q <= alu_rsp.result;
        RS_T2:   t2_q <= alu_rsp.result;
        default: ;
      endcase
      // Advance x to the step end together with the final y update
      if (pc_q == LAST_UOP) begin
        x_q <= xe_q;
      end
    end
  end

  // Output register: hold the point until the sink takes it
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_x_q    <= x_q;
      out_y_q    <= y_q;
      out_last_q <= pt_last;
      out_sat_q  <= sat_q;
    end
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.point_x    = out_x_q;
  assign out_o.point_y    = out_y_q;
  assign out_o.last_point = out_last_q;
  assign out_o.saturated  = out_sat_q;

`ifndef SYNTHESIS
  // A new run starts with a clean flag at the first operation and step
  a_run_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |=> (!sat_q && step_q == '0 && pc_q == '0 && state_q == ST_EMIT))
    else $error("run did not start cleanly");
  // The program counter never runs past the micro-program
  a_pc_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_WB || state_q == ST_ISSUE) |-> (pc_q <= LAST_UOP))
    else $error("program counter out of range");
  // The step counter never passes the requested step count
  a_step_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_IDLE) |-> (step_q <= steps_q && steps_q <= STEP_CAP))
    else $error("step counter out of range");
  // Sending the final point returns the sequencer to idle
  a_last_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_load && pt_last) |=> (state_q == ST_IDLE && out_valid_q && out_last_q))
    else $error("run did not finish after the final point");
`endif

endmodule

// File: test/rk4_point_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RK4 integrator point checker
// Watches the run and point channels and the step size register. For each
// accepted run it works out every solution point in Q16.16. It then compares
// the points that leave the block, in order, field by field.
// ----------------------------------------------------------------------------
module rk4_point_checker import rk4_pkg::*; #(
  parameter int unsigned MAX_STEPS = MAX_STEPS_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cfg_we_i,
  input  logic [HW-1:0] cfg_wdata_i,
  rk4_in_if             run_mon,
  rk4_out_if            point_mon,
  output int unsigned   fail_count_o,
  output int unsigned   pending_o
);

  localparam longint Q_HI = 64'sd2147483647;
  localparam longint Q_LO = -64'sd2147483648;
  localparam int unsigned REPORT_LINES = 30;

  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic               last;
    logic               sat;
  } point_t;

  point_t      point_q[$];
  point_t      want;
  logic [HW-1:0] step_q;
  logic        run_sat;
  int unsigned point_idx;

  initial begin
    fail_count_o = 0;
    pending_o    = 0;
    point_idx    = 0;
  end

  function automatic logic signed [31:0] sat32(input longint v);
    if (v > Q_HI) begin
      run_sat = 1'b1;
      return 32'sh7FFF_FFFF;
    end
    if (v < Q_LO) begin
      run_sat = 1'b1;
      return 32'sh8000_0000;
    end
    return v[31:0];
  endfunction

  function automatic logic signed [31:0] q_add(input logic signed [31:0] a,
                                               input logic signed [31:0] b);
    return sat32(longint'(a) + longint'(b));
  endfunction

  // exact product, round half up, drop 16 fraction bits
  function automatic logic signed [31:0] q_mul(input logic signed [31:0] a,
                                               input logic signed [31:0] b);
    longint p;
    p = longint'(a) * longint'(b);
    return sat32((p + 64'sd32768) >>> 16);
  endfunction

  // dy/dx = -3y + x^2
  function automatic logic signed [31:0] slope(input logic signed [31:0] x,
                                               input logic signed [31:0] y);
    logic signed [31:0] t;
    t = sat32(longint'(y) * -64'sd3);
    return q_add(t, q_mul(x, x));
  endfunction

  function automatic void predict_run(input logic signed [31:0] x0,
                                      input logic signed [31:0] y0,
                                      input logic [5:0] cnt);
    logic signed [31:0] x, y, h, hh, xm, xe, k1, k2, k3, k4, wsum;
    longint      t, d;
    int unsigned n, i;
    point_t      p;
    n       = (cnt > MAX_STEPS) ? MAX_STEPS : cnt;
    x       = x0;
    y       = y0;
    h       = {1'b0, step_q};
    hh      = h >>> 1;
    run_sat = 1'b0;
    p = '{x: x, y: y, last: (n == 0), sat: 1'b0};
    point_q.push_back(p);
    for (i = 0; i < n; i++) begin
      xm   = q_add(x, hh);
      xe   = q_add(x, h);
      k1   = slope(x, y);
      k2   = slope(xm, q_add(y, q_mul(k1, h) >>> 1));
      k3   = slope(xm, q_add(y, q_mul(k2, h) >>> 1));
      k4   = slope(xe, q_add(y, q_mul(k3, h)));
      wsum = sat32(longint'(k1) + 2 * longint'(k2) + 2 * longint'(k3) + longint'(k4));
      t    = longint'(q_mul(wsum, h));
      // divide by 6, nearest with halves away from zero
      d    = (t >= 0) ? (t + 3) / 6 : (t - 3) / 6;
      y    = q_add(y, d[31:0]);
      x    = xe;
      p = '{x: x, y: y, last: (i + 1 == n), sat: run_sat};
      point_q.push_back(p);
    end
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] exp_val);
    fail_count_o++;
    if (fail_count_o <= REPORT_LINES)
      $display("%0t: point %0d %s: got %h, expected %h",
               $time, point_idx, what, got, exp_val);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q = STEP_RESET;
      point_q.delete();
      pending_o = 0;
    end else begin
      if (point_mon.valid && point_mon.ready) begin
        point_idx++;
        if (point_q.size() == 0) begin
          report_mismatch("arrived with nothing expected", point_mon.point_x, '0);
        end else begin
          want = point_q.pop_front();
          if (point_mon.point_x !== want.x)
            report_mismatch("point_x", point_mon.point_x, want.x);
          if (point_mon.point_y !== want.y)
            report_mismatch("point_y", point_mon.point_y, want.y);
          if (point_mon.last_point !== want.last)
            report_mismatch("last_point", 32'(point_mon.last_point), 32'(want.last));
          if (point_mon.saturated !== want.sat)
            report_mismatch("saturated", 32'(point_mon.saturated), 32'(want.sat));
        end
      end
      if (run_mon.valid && run_mon.ready)
        predict_run(run_mon.start_x, run_mon.start_y, run_mon.step_count);
      if (cfg_we_i)
        step_q = cfg_wdata_i;
      pending_o = point_q.size();
    end
  end

endmodule

// File: test/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RK4 integrator testbench
// Drives runs into the integrator under several step sizes: directed corner
// runs first, then random runs. Both channels idle at random. A checker beside
// the block predicts and compares every point; this top gives the verdict.
// ----------------------------------------------------------------------------
module testbench;
  import rk4_pkg::*;

  localparam int unsigned RANDOM_RUNS  = 400;
  localparam int unsigned PHASE_RUNS   = 60;   // runs between step size changes
  localparam int unsigned IDLE_PCT     = 13;   // idle chance per cycle, each side
  localparam int unsigned CALM_FIRST   = 200;  // window of runs with no idling
  localparam int unsigned CALM_LAST    = 280;
  localparam int unsigned HOLD_RUN     = 130;  // sender waits for all points here
  localparam int unsigned STALL_LIMIT  = 3000; // cycles with no transfer at all
  localparam int unsigned DRAIN_CYCLES = 80;   // idle cycles after the last drain

  localparam logic signed [31:0] Q_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] Q_MIN = 32'sh8000_0000;
  localparam logic signed [31:0] Q_ONE = 32'sh0001_0000;

  logic          clk_i = 1'b0;
  logic          rst_ni;
  logic          cfg_we_i;
  logic [HW-1:0] cfg_wdata_i;
  logic          calm;
  int unsigned   fail_count;
  int unsigned   pending;
  int unsigned   quiet_cycles;
  int unsigned   i;

  rk4_in_if  run_ch ();
  rk4_out_if point_ch ();

  rk4_ode_integrator DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .in_i       (run_ch),
    .out_o      (point_ch)
  );

  rk4_point_checker u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .run_mon     (run_ch),
    .point_mon   (point_ch),
    .fail_count_o(fail_count),
    .pending_o   (pending)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Stall the point channel at random, except inside the calm window.
  always @(negedge clk_i) begin
    point_ch.ready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
  end

  // Count cycles with no transfer on either channel; a hung block ends here.
  always @(posedge clk_i) begin
    if (!rst_ni || (run_ch.valid && run_ch.ready) || (point_ch.valid && point_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == STALL_LIMIT) begin
      $display("FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Offer one run and hold it until the block takes it. Enter and leave at a
  // falling edge; valid stays high on exit so that a back-to-back run needs
  // no second assignment in the same step.
  task automatic send_run(input logic signed [31:0] x, input logic signed [31:0] y,
                          input logic [5:0] n);
    while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
      // idle cycle: drop valid and scramble the payload
      run_ch.valid      <= 1'b0;
      run_ch.start_x    <= $urandom();
      run_ch.start_y    <= $urandom();
      run_ch.step_count <= 6'($urandom());
      @(negedge clk_i);
    end
    run_ch.valid      <= 1'b1;
    run_ch.start_x    <= x;
    run_ch.start_y    <= y;
    run_ch.step_count <= n;
    do @(posedge clk_i); while (!run_ch.ready);
    @(negedge clk_i);
  endtask

  // Drop valid and wait until every predicted point has come out.
  task automatic drain_points();
    run_ch.valid <= 1'b0;
    do @(negedge clk_i); while (pending != 0);
  endtask

  // Write the step size; call only while the block is idle.
  task automatic set_step(input logic [HW-1:0] h);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= h;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  // Mostly modest coordinates so runs integrate for real; some wide values
  // and exact extremes to hit saturation.
  function automatic logic signed [31:0] pick_coord();
    logic signed [31:0] v;
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: v = $signed($urandom_range(0, 32'h0010_0000)) - 32'sh0008_0000;
      5, 6:          v = $signed($urandom_range(0, 32'h0200_0000)) - 32'sh0100_0000;
      7: begin
        case ($urandom_range(0, 4))
          0:       v = Q_MIN;
          1:       v = Q_MAX;
          2:       v = '0;
          3:       v = -32'sd1;
          default: v = 32'sd1;
        endcase
      end
      default:       v = $urandom();
    endcase
    return v;
  endfunction

  // Short runs dominate to keep the cycle count down; a few go long.
  function automatic logic [5:0] pick_count();
    int unsigned k;
    k = $urandom_range(0, 99);
    if (k < 70)
      return 6'($urandom_range(0, 6));
    else if (k < 95)
      return 6'($urandom_range(7, 24));
    return 6'($urandom_range(25, 63));
  endfunction

  function automatic logic [HW-1:0] phase_step(input int unsigned phase);
    case (phase)
      0:       return HW'(1);
      1:       return {HW{1'b1}};
      2:       return HW'(32'h0001_0000);
      3:       return '0;  // zero step: every point repeats the start
      4:       return HW'($urandom_range(1, 32'h0004_0000));
      5:       return HW'($urandom());
      default: return STEP_RESET;
    endcase
  endfunction

  initial begin
    rst_ni            = 1'b0;
    cfg_we_i          = 1'b0;
    cfg_wdata_i       = '0;
    calm              = 1'b0;
    run_ch.valid      = 1'b0;
    run_ch.start_x    = '0;
    run_ch.start_y    = '0;
    run_ch.step_count = '0;
    point_ch.ready    = 1'b0;
    repeat (9) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed runs under the reset step size.
    send_run('0, '0, 6'd0);                       // start point only
    send_run('0, '0, 6'd1);
    send_run(Q_ONE, Q_ONE, 6'd5);
    send_run(Q_MAX, Q_MAX, 6'd2);
    send_run(Q_MIN, Q_MIN, 6'd2);
    send_run(Q_MIN, Q_MAX, 6'd1);
    send_run(Q_MAX, Q_MIN, 6'd1);
    send_run(-32'sd1, -32'sd1, 6'd3);
    send_run('0, Q_ONE, 6'd63);                   // full-length run
    send_run(-32'sh0002_0000, 32'sh0000_8000, 6'd10);
    send_run(32'sh00B6_0000, '0, 6'd4);           // x^2 crosses the top
    send_run(Q_MAX - 32'sd1000, '0, 6'd3);        // x + h saturates
    send_run('0, 32'sh2AAB_0000, 6'd2);           // -3y just past the bottom
    send_run('0, -32'sh2AAB_0000, 6'd2);          // -3y just past the top
    send_run(Q_ONE, -Q_ONE, 6'd32);

    // Zero step size.
    drain_points();
    set_step('0);
    send_run(Q_ONE, 32'sh0002_0000, 6'd3);
    send_run(Q_MIN, 32'sd5, 6'd2);

    // Random runs, changing the step size between phases.
    for (i = 0; i < RANDOM_RUNS; i++) begin
      if (i % PHASE_RUNS == 0) begin
        drain_points();
        set_step(phase_step(i / PHASE_RUNS));
      end
      if (i == HOLD_RUN)
        drain_points();
      calm <= (i >= CALM_FIRST) && (i < CALM_LAST);
      send_run(pick_coord(), pick_coord(), pick_count());
    end

    // Let the last points out, then give the block time to settle.
    drain_points();
    repeat (DRAIN_CYCLES) @(negedge clk_i);
    if (fail_count == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule

// File: sim.f
design/rk4_pkg.sv
design/rk4_if.sv
design/rk4_alu.sv
design/rk4_ode_integrator.sv
test/rk4_point_checker.sv
test/testbench.sv
